// ===== rtl/mrwt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrwt_pkg
// Shared constants and types for the strong probable prime test block.
// ----------------------------------------------------------------------------
package mrwt_pkg;

  localparam int NumWidth = 32;
  localparam int CntWidth = $clog2(NumWidth + 1);

  typedef logic [NumWidth-1:0] num_t;
  typedef logic [CntWidth-1:0] cnt_t;

  // top level sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SCAN,
    ST_POW_MUL,
    ST_POW_SQR,
    ST_CHECK,
    ST_CHAIN,
    ST_DONE
  } state_t;

  // handshake between sequencer and modular multiplier
  typedef struct packed {
    logic start;
  } mm_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/mrwt_modmul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrwt_modmul
// Bit-serial modular multiplier: (x * y) mod m, one multiplier bit per cycle,
// most significant bit first. x and y must be below m.
// ----------------------------------------------------------------------------
module mrwt_modmul (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire mrwt_pkg::mm_req_t req,
  input  wire mrwt_pkg::num_t  x,
  input  wire mrwt_pkg::num_t  y,
  input  wire mrwt_pkg::num_t  m,
  output mrwt_pkg::mm_rsp_t    rsp,
  output mrwt_pkg::num_t       prod
);
  import mrwt_pkg::*;

  num_t acc_r, acc_nxt;
  num_t ysh_r, ysh_nxt;
  cnt_t cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;

  num_t dbl;
  num_t room;

  // add_mod helper: (p + q) mod m with p, q < m
  function automatic num_t add_mod(input num_t p, input num_t q, input num_t mm);
    num_t rm;
    rm = mm - q;
    return (p >= rm) ? (p - rm) : (p + q);
  endfunction

  // one step: double, then add x when the current bit is set
  always_comb begin
    dbl = add_mod(acc_r, acc_r, m);
    room = ysh_r[NumWidth-1] ? add_mod(dbl, x, m) : dbl;
  end

  always_comb begin
    acc_nxt = acc_r;
    ysh_nxt = ysh_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start && !busy_r) begin
      acc_nxt = '0;
      ysh_nxt = y;
      cnt_nxt = cnt_t'(NumWidth);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = room;
      ysh_nxt = {ysh_r[NumWidth-2:0], 1'b0};
      cnt_nxt = cnt_r - cnt_t'(1);
      if (cnt_r == cnt_t'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    ysh_r <= ysh_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign prod = acc_r;

endmodule
`default_nettype wire

// ===== rtl/miller_rabin_witness_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// miller_rabin_witness_test
// Strong probable prime test of a candidate n against one witness base a.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid / in_stall carry one item (in_candidate, in_witness). The block
//   takes an item only while idle with no result pending delivery.
//   out_valid / out_stall carry one result bit, out_probable_prime, per item.
//   Operation: a mod n is reduced bit-serially, then the trailing zeros of
//   n-1 are counted and the leading zeros of its odd part shifted out to
//   align the exponent. Each modular product then runs in the shared
//   bit-serial multiplier (start, 32 steps, hand-back). Square-and-multiply
//   and the squaring chain together need at most 62 products; n < 2 or
//   a < 2 goes straight to the done state and gives a zero result.
//   Throughput: one item at a time, bounded by the serial multiplier.
//   Reset (rst_n low, synchronous) returns to idle and drops any result.
//   While out_stall is high the result holds and no new item is accepted.
// ----------------------------------------------------------------------------
module miller_rabin_witness_test (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_candidate,
  input  wire logic [31:0] in_witness,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_probable_prime
);
  import mrwt_pkg::*;

  state_t state_r, state_nxt;
  num_t n_r, n_nxt;
  num_t a_r, a_nxt;      // witness, later base reduced mod n
  num_t rem_r, rem_nxt;  // remainder during reduction
  num_t e_r, e_nxt;      // exponent shift register (n-1)
  num_t x_r, x_nxt;
  cnt_t cnt_r, cnt_nxt;
  cnt_t s_r, s_nxt;      // number of trailing zeros of n-1
  logic res_r, res_nxt;
  logic ov_r, ov_nxt;

  mm_req_t mm_req;
  mm_rsp_t mm_rsp;
  num_t mm_x, mm_y, mm_p;
  num_t nm1;
  logic [NumWidth:0] rem_sh;
  logic bit_d;

  // trailing zero count stays within the word
  function automatic logic s_nxt_guard(input cnt_t s);
    return s < cnt_t'(NumWidth - 1);
  endfunction

  assign nm1 = n_r - num_t'(1);

  mrwt_modmul u_mm (
    .clk(clk), .rst_n(rst_n), .req(mm_req),
    .x(mm_x), .y(mm_y), .m(n_r), .rsp(mm_rsp), .prod(mm_p)
  );

  // one restoring step of a mod n
  assign rem_sh = {rem_r, a_r[NumWidth-1]};

  // current exponent bit below the leading one
  assign bit_d = e_r[NumWidth-1];

  // operand selection for the multiplier
  always_comb begin
    mm_req.start = 1'b0;
    mm_x = x_r;
    mm_y = x_r;
    case (state_r)
      ST_POW_SQR: begin
        mm_req.start = !mm_rsp.busy && !mm_rsp.done;
      end
      ST_POW_MUL: begin
        mm_x = a_r;
        mm_req.start = !mm_rsp.busy && !mm_rsp.done;
      end
      ST_CHAIN: begin
        mm_req.start = !mm_rsp.busy && !mm_rsp.done;
      end
      default: begin
        mm_req.start = 1'b0;
      end
    endcase
  end

  // next state and datapath
  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r;
    a_nxt = a_r;
    rem_nxt = rem_r;
    e_nxt = e_r;
    x_nxt = x_r;
    cnt_nxt = cnt_r;
    s_nxt = s_r;
    res_nxt = res_r;
    ov_nxt = ov_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && !ov_r) begin
          n_nxt = num_t'(in_candidate);
          a_nxt = num_t'(in_witness);
          rem_nxt = '0;
          cnt_nxt = cnt_t'(NumWidth);
          if (num_t'(in_candidate) < num_t'(2) || num_t'(in_witness) < num_t'(2)) begin
            res_nxt = 1'b0;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        a_nxt = {a_r[NumWidth-2:0], 1'b0};
        if (rem_sh >= {1'b0, n_r}) rem_nxt = num_t'(rem_sh - {1'b0, n_r});
        else rem_nxt = num_t'(rem_sh);
        cnt_nxt = cnt_r - cnt_t'(1);
        if (cnt_r == cnt_t'(1)) state_nxt = ST_SCAN;
        e_nxt = nm1;
        s_nxt = '0;
      end
      ST_SCAN: begin
        // rem_r holds a mod n; count trailing zeros of n-1 and align exponent
        if (rem_r == '0) begin
          res_nxt = 1'b1;
          state_nxt = ST_DONE;
        end else if (cnt_r == '0) begin
          // first entry: count trailing zeros a bit per cycle
          if (!e_r[0] && s_nxt_guard(s_r)) begin
            e_nxt = e_r >> 1;
            s_nxt = s_r + cnt_t'(1);
          end else begin
            a_nxt = rem_r;
            cnt_nxt = cnt_t'(1);
          end
        end else if (!bit_d) begin
          // count the shifts so cnt_r ends at the first bit position to process
          e_nxt = {e_r[NumWidth-2:0], 1'b0};
          cnt_nxt = cnt_r + cnt_t'(1);
        end else begin
          // leading one consumed: x = a
          x_nxt = rem_r;
          e_nxt = {e_r[NumWidth-2:0], 1'b0};
          state_nxt = (cnt_r == cnt_t'(NumWidth)) ? ST_CHECK : ST_POW_SQR;
        end
      end
      ST_POW_SQR: begin
        if (mm_rsp.done) begin
          x_nxt = mm_p;
          if (bit_d) state_nxt = ST_POW_MUL;
          else begin
            e_nxt = {e_r[NumWidth-2:0], 1'b0};
            cnt_nxt = cnt_r + cnt_t'(1);
            if (cnt_r == cnt_t'(NumWidth - 1)) state_nxt = ST_CHECK;
          end
        end
      end
      ST_POW_MUL: begin
        if (mm_rsp.done) begin
          x_nxt = mm_p;
          e_nxt = {e_r[NumWidth-2:0], 1'b0};
          cnt_nxt = cnt_r + cnt_t'(1);
          state_nxt = (cnt_r == cnt_t'(NumWidth - 1)) ? ST_CHECK : ST_POW_SQR;
        end
      end
      ST_CHECK: begin
        if (x_r == num_t'(1) || x_r == nm1) begin
          res_nxt = 1'b1;
          state_nxt = ST_DONE;
        end else if (s_r <= cnt_t'(1)) begin
          res_nxt = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_t'(1);
          state_nxt = ST_CHAIN;
        end
      end
      ST_CHAIN: begin
        if (mm_rsp.done) begin
          x_nxt = mm_p;
          cnt_nxt = cnt_r + cnt_t'(1);
          if (mm_p == nm1) begin
            res_nxt = 1'b1;
            state_nxt = ST_DONE;
          end else if (mm_p == num_t'(1) || cnt_r + cnt_t'(1) >= s_r) begin
            res_nxt = 1'b0;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        ov_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (ov_r && !out_stall) ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
      cnt_r <= cnt_nxt;
    end
    n_r <= n_nxt;
    a_r <= a_nxt;
    rem_r <= rem_nxt;
    e_r <= e_nxt;
    x_r <= x_nxt;
    s_r <= s_nxt;
    res_r <= res_nxt;
  end

  // handshake outputs
  always_comb begin
    in_stall = (state_r != ST_IDLE) || ov_r;
    out_valid = ov_r;
    out_probable_prime = res_r;
  end

endmodule
`default_nettype wire
